/* src/i2crr_pkg.sv */
// ----------------------------------------------------------------------------
// i2crr_pkg
// Types, register indexes and reset values shared by the I2C register-read
// master and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crr_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd1;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd56;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // which written byte is on the bus
  localparam logic [1:0] SLOT_WR_ADDR = 2'd0;
  localparam logic [1:0] SLOT_REG     = 2'd1;
  localparam logic [1:0] SLOT_RD_ADDR = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       kind;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       busy_res;
    logic       transfer_done;
  } out_item_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] half_ticks;
  } cfg_t;

  typedef enum logic [21:0] {
    PH_IDLE       = 22'h000001,
    PH_PRE        = 22'h000002,
    PH_START      = 22'h000004,
    PH_START_LOW  = 22'h000008,
    PH_WBIT_SETUP = 22'h000010,
    PH_WBIT_HIGH  = 22'h000020,
    PH_WBIT_LOW   = 22'h000040,
    PH_WACK_REL   = 22'h000080,
    PH_WACK_HIGH  = 22'h000100,
    PH_RS_SDAH    = 22'h000200,
    PH_RS_SCLH    = 22'h000400,
    PH_RS_SDAL    = 22'h000800,
    PH_RS_SCLL    = 22'h001000,
    PH_RBIT_LOW   = 22'h002000,
    PH_RBIT_HIGH  = 22'h004000,
    PH_ACK_LOW    = 22'h008000,
    PH_ACK_HIGH   = 22'h010000,
    PH_NACK_LOW   = 22'h020000,
    PH_NACK_HIGH  = 22'h040000,
    PH_NACK_END   = 22'h080000,
    PH_STOP_SETUP = 22'h100000,
    PH_STOP_HIGH  = 22'h200000
  } phase_t;

endpackage

`default_nettype wire

/* src/i2crr_cfg.sv */
// ----------------------------------------------------------------------------
// i2crr_cfg
// Configuration registers: slave address and SCL half period.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [i2crr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [i2crr_pkg::CFG_DATA_W-1:0] wr_data,
  output      i2crr_pkg::cfg_t                  cfg
);
  import i2crr_pkg::*;

  logic [6:0] dev_addr_r;
  logic [7:0] half_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      half_ticks_r <= HALF_PERIOD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEV_ADDR:    dev_addr_r   <= wr_data[6:0];
        REG_HALF_PERIOD: half_ticks_r <= wr_data;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  assign cfg.dev_addr   = dev_addr_r;
  assign cfg.half_ticks = half_ticks_r;

endmodule

`default_nettype wire

/* src/i2crr_seq.sv */
// ----------------------------------------------------------------------------
// i2crr_seq
// Bus phase sequencer: state registers plus the one-beat next-state and
// result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crr_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire i2crr_pkg::in_item_t  item,
  input  wire i2crr_pkg::cfg_t      cfg,
  output      i2crr_pkg::out_item_t result
);
  import i2crr_pkg::*;

  phase_t     phase_r,   phase_nxt;
  logic [3:0] bit_r,     bit_nxt;
  logic [7:0] left_r,    left_nxt;
  logic [7:0] shift_r,   shift_nxt;
  logic [7:0] tick_r,    tick_nxt;
  logic [7:0] held_r,    held_nxt;
  logic       scl_r,     scl_nxt;
  logic       sda_r,     sda_nxt;
  logic       drv_r,     drv_nxt;
  logic [1:0] slot_r,    slot_nxt;

  logic       valid;
  logic       last;
  logic       done;
  logic [7:0] byte_out;
  logic [7:0] wr_addr;
  logic [7:0] rd_addr;
  logic [3:0] bit_inc;
  logic [7:0] shift_up;

  assign wr_addr  = {cfg.dev_addr, 1'b0};
  assign rd_addr  = {cfg.dev_addr, 1'b1};
  assign bit_inc  = bit_r + 4'd1;
  assign shift_up = {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    held_nxt  = held_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    slot_nxt  = slot_r;
    valid     = 1'b0;
    last      = 1'b0;
    done      = 1'b0;
    byte_out  = 8'd0;

    if (item.kind == KIND_START) begin
      // a start while busy is dropped
      if (phase_r == PH_IDLE) begin
        held_nxt  = item.reg_addr;
        left_nxt  = item.byte_count;
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
        drv_nxt   = 1'b1;
        phase_nxt = PH_PRE;
        tick_nxt  = cfg.half_ticks;
      end
    end else if (phase_r != PH_IDLE) begin
      if (tick_r > 8'd1) begin
        tick_nxt = tick_r - 8'd1;
      end else begin
        tick_nxt = cfg.half_ticks;
        case (phase_r)
          PH_PRE: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_START;
          end
          PH_START: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_START_LOW;
          end
          PH_START_LOW: begin
            shift_nxt = wr_addr;
            bit_nxt   = 4'd0;
            slot_nxt  = SLOT_WR_ADDR;
            scl_nxt   = 1'b0;
            drv_nxt   = 1'b1;
            sda_nxt   = wr_addr[7];
            phase_nxt = PH_WBIT_SETUP;
          end
          PH_WBIT_SETUP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WBIT_HIGH;
          end
          PH_WBIT_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_WBIT_LOW;
          end
          PH_WBIT_LOW: begin
            bit_nxt   = bit_inc;
            shift_nxt = shift_up;
            if (bit_inc < BITS_PER_BYTE) begin
              sda_nxt   = shift_up[7];
              phase_nxt = PH_WBIT_SETUP;
            end else begin
              drv_nxt   = 1'b0;
              phase_nxt = PH_WACK_REL;
            end
          end
          PH_WACK_REL: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WACK_HIGH;
          end
          PH_WACK_HIGH: begin
            // slave acknowledge is not examined
            scl_nxt = 1'b0;
            drv_nxt = 1'b1;
            if (slot_r == SLOT_WR_ADDR) begin
              shift_nxt = held_r;
              bit_nxt   = 4'd0;
              slot_nxt  = SLOT_REG;
              sda_nxt   = held_r[7];
              phase_nxt = PH_WBIT_SETUP;
            end else if (slot_r == SLOT_REG) begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_RS_SDAH;
            end else if (left_r != 8'd0) begin
              drv_nxt   = 1'b0;
              shift_nxt = 8'd0;
              bit_nxt   = 4'd0;
              phase_nxt = PH_RBIT_LOW;
            end else begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_NACK_LOW;
            end
          end
          PH_RS_SDAH: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_RS_SCLH;
          end
          PH_RS_SCLH: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_RS_SDAL;
          end
          PH_RS_SDAL: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RS_SCLL;
          end
          PH_RS_SCLL: begin
            shift_nxt = rd_addr;
            bit_nxt   = 4'd0;
            slot_nxt  = SLOT_RD_ADDR;
            scl_nxt   = 1'b0;
            drv_nxt   = 1'b1;
            sda_nxt   = rd_addr[7];
            phase_nxt = PH_WBIT_SETUP;
          end
          PH_RBIT_LOW: begin
            // sample on the rising SCL edge
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], item.sda_in};
            phase_nxt = PH_RBIT_HIGH;
          end
          PH_RBIT_HIGH: begin
            scl_nxt = 1'b0;
            bit_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_nxt = PH_RBIT_LOW;
            end else begin
              valid    = 1'b1;
              byte_out = shift_r;
              last     = (left_r == 8'd1);
              left_nxt = left_r - 8'd1;
              drv_nxt  = 1'b1;
              if (left_r != 8'd1) begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_ACK_LOW;
              end else begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_NACK_LOW;
              end
            end
          end
          PH_ACK_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_ACK_HIGH;
          end
          PH_ACK_HIGH: begin
            scl_nxt   = 1'b0;
            drv_nxt   = 1'b0;
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            phase_nxt = PH_RBIT_LOW;
          end
          PH_NACK_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_NACK_HIGH;
          end
          PH_NACK_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_NACK_END;
          end
          PH_NACK_END: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP_SETUP;
          end
          PH_STOP_SETUP: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_STOP_HIGH;
          end
          PH_STOP_HIGH: begin
            sda_nxt   = 1'b1;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            tick_nxt  = 8'd0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            tick_nxt  = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= 4'd0;
      left_r  <= 8'd0;
      shift_r <= 8'd0;
      tick_r  <= 8'd0;
      held_r  <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b0;
      slot_r  <= SLOT_WR_ADDR;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      left_r  <= left_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      held_r  <= held_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign result.scl_level     = scl_nxt;
  assign result.sda_level     = sda_nxt;
  assign result.sda_drive     = drv_nxt;
  assign result.read_byte     = byte_out;
  assign result.byte_valid    = valid;
  assign result.last_byte     = last;
  assign result.busy_res      = (phase_nxt != PH_IDLE);
  assign result.transfer_done = done;

endmodule

`default_nettype wire

/* src/i2c_register_read_master.sv */
// ----------------------------------------------------------------------------
// i2c_register_read_master
// Tick-driven I2C master that performs one register read per start command.
// ----------------------------------------------------------------------------
// Each input beat is either a time tick or a start command, and each input
// beat produces exactly one result beat carrying the SCL/SDA levels and
// drive enable after that beat, plus any byte completed on it. The block
// takes one beat per clock: the sequencer state and the result register
// both load in the cycle a beat is accepted, so the sole limit on rate is
// the output register, which is refilled in the same cycle it is drained.
// A transfer is start, write address, register byte, repeated start, read
// address, byte_count read bytes (ACK on all but the last), NACK and stop;
// every level change is held for half_period_ticks ticks. The slave's ACK
// to written bytes is clocked but not checked. Read bits are sampled from
// sda_in on the tick SCL rises. A start arriving while busy is dropped.
// Configuration writes are always accepted and take effect at the next use.
`default_nettype none

module i2c_register_read_master (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input beats
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire i2crr_pkg::in_item_t              in_data,
  // result beats
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      i2crr_pkg::out_item_t             out_data,
  // configuration writes
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [i2crr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [i2crr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2crr_pkg::*;

  cfg_t      cfg;
  out_item_t result;
  logic      step_en;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign cfg_ready = 1'b1;

  // accept whenever the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;

  i2crr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2crr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/i2crr_checker.sv */
// ----------------------------------------------------------------------------
// i2crr_checker
// Port-level checks for the I2C register-read master, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crr_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire i2crr_pkg::out_item_t out_data
);
  import i2crr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an empty result slot never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // stop leaves the bus idle-high and the block not busy
  a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_done |->
      !out_data.busy_res && out_data.scl_level && out_data.sda_level &&
      out_data.sda_drive && !out_data.byte_valid)
    else $error("bad bus state at stop");

  // a completed byte comes with SCL low and SDA driven for ACK or NACK
  a_byte_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |->
      !out_data.scl_level && out_data.sda_drive && out_data.busy_res &&
      (out_data.sda_level == out_data.last_byte))
    else $error("bad bus state at byte completion");

endmodule

bind i2c_register_read_master i2crr_checker u_i2crr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
